/* rtl/smms_pkg.sv */
package smms_pkg;

  localparam int SUM_W   = 42;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int EPOCH_W = 8;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_LINK,
    ST_ADD,
    ST_WRL,
    ST_WRR,
    ST_DONE
  } state_t;

endpackage

/* rtl/segment_merge_max_sum_unit.sv */
// Running maximum segment sum over a row of NUM_SLOTS slots.
// Input channel s_axis: one item activates slot `index` with `value`; tuser
// carries start_req, which clears all slots and the running maximum first.
// Output channel m_axis: one item per input item, the largest segment sum
// seen since the last start.
// Each segment [lo, hi] is kept at its two end slots in one memory: the low
// end holds hi and the sum, the high end holds lo and the sum, so a new slot
// finds both neighbor segments with two reads and no parent walk.
// An item that activates a slot passes READ, WAIT, LINK, ADD, WRL, WRR and
// DONE; one that is ignored (slot out of range or already active) passes
// READ, WAIT and DONE. The next item is taken in the cycle after a result is
// loaded. One item is in flight at a time; the memory ports shape the steps
// (three reads, then three single-port writes).
// Active slots carry an 8-bit run tag; a start bumps the tag. After reset,
// and on every 255th start, a clearing pass over all NUM_SLOTS slots resets the
// tags; no item is taken during it.
// A result waits in the output register while m_axis_tready is low; the next
// input item is still accepted and runs until its own result is due.
module segment_merge_max_sum_unit #(
  parameter int NUM_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // index[9:0], value[41:10], zero fill
  input  logic        s_axis_tuser,   // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // max_sum[41:0], zero fill
);
  import smms_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WW = EPOCH_W + AW + SUM_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SLOTS - 1);

  logic [WW-1:0] mem [NUM_SLOTS];

  state_t state, state_next;

  logic [EPOCH_W-1:0] epoch;
  logic [AW-1:0]      clr_cnt;
  logic               pending;
  logic [AW-1:0]      idx;
  logic               in_range;
  logic               right_in_range;
  logic [SUM_W-1:0]   val;
  logic [SUM_W-1:0]   run_max;
  logic               has_left;
  logic               has_right;
  logic [AW-1:0]      lo;
  logic [AW-1:0]      hi;
  logic [SUM_W-1:0]   lsum;
  logic [SUM_W-1:0]   rsum;
  logic [SUM_W-1:0]   s1;
  logic [SUM_W-1:0]   total;
  logic [SUM_W-1:0]   out_sum;
  logic               out_valid;

  logic [AW-1:0] rd_a_addr, rd_b_addr;
  logic [WW-1:0] rdata_a, rdata_b;
  logic          we;
  logic [AW-1:0] wa;
  logic [WW-1:0] wd;

  logic               in_accept;
  logic               in_start;
  logic [IDX_W-1:0]   in_index;
  logic [VAL_W-1:0]   in_value;
  logic               out_load;

  logic [EPOCH_W-1:0] tag_a, tag_b;
  logic [AW-1:0]      link_a, link_b;
  logic [SUM_W-1:0]   sum_a, sum_b;

  assign in_start  = s_axis_tuser;
  assign in_index  = s_axis_tdata[IDX_W-1:0];
  assign in_value  = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state == ST_DONE) && (!out_valid || m_axis_tready);

  assign tag_a  = rdata_a[WW-1:AW+SUM_W];
  assign link_a = rdata_a[AW+SUM_W-1:SUM_W];
  assign sum_a  = rdata_a[SUM_W-1:0];
  assign tag_b  = rdata_b[WW-1:AW+SUM_W];
  assign link_b = rdata_b[AW+SUM_W-1:SUM_W];
  assign sum_b  = rdata_b[SUM_W-1:0];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(48 - SUM_W)'(0), out_sum};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_a <= mem[rd_a_addr];
    rdata_b <= mem[rd_b_addr];
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    rd_a_addr     = idx;
    rd_b_addr     = idx - AW'(1);
    we            = 1'b0;
    wa            = idx;
    wd            = {epoch, idx, total};
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt;
        wd = '0;
        if (clr_cnt == LAST_SLOT) begin
          state_next = pending ? ST_READ : ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser && epoch == EPOCH_LAST) ? ST_CLEAR : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        rd_a_addr = idx + AW'(1);
        if (!in_range || tag_a == epoch) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        we         = 1'b1;
        wa         = idx;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        state_next = ST_WRL;
      end
      ST_WRL: begin
        we         = 1'b1;
        wa         = lo;
        wd         = {epoch, hi, total};
        state_next = ST_WRR;
      end
      ST_WRR: begin
        we         = 1'b1;
        wa         = hi;
        wd         = {epoch, lo, total};
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= EPOCH_FIRST;
      clr_cnt   <= '0;
      pending   <= 1'b0;
      run_max   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
        end
        ST_IDLE: begin
          if (in_accept) begin
            pending <= 1'b1;
            clr_cnt <= '0;
            if (in_start) begin
              run_max <= '0;
              epoch   <= (epoch == EPOCH_LAST) ? EPOCH_FIRST : epoch + EPOCH_W'(1);
            end
          end
        end
        ST_LINK: begin
          if (val > run_max) begin
            run_max <= val;
          end
        end
        ST_ADD: begin
          if (s1 > run_max) begin
            run_max <= s1;
          end
        end
        ST_WRL: begin
          if (total > run_max) begin
            run_max <= total;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            pending <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      idx            <= AW'(in_index);
      in_range       <= 32'(in_index) < NUM_SLOTS;
      right_in_range <= (32'(in_index) + 32'd1) < NUM_SLOTS;
      val            <= SUM_W'(in_value);
    end
    if (state == ST_WAIT) begin
      has_left <= (idx != '0) && (tag_b == epoch);
      lo       <= ((idx != '0) && (tag_b == epoch)) ? link_b : idx;
      lsum     <= sum_b;
    end
    if (state == ST_LINK) begin
      has_right <= right_in_range && (tag_a == epoch);
      hi        <= (right_in_range && (tag_a == epoch)) ? link_a : idx;
      rsum      <= sum_a;
      s1        <= has_left ? lsum + val : val;
    end
    if (state == ST_ADD) begin
      total <= has_right ? s1 + rsum : s1;
    end
    if (out_load) begin
      out_sum <= run_max;
    end
  end

endmodule
